FILE: sv/ckl_pkg.sv
// Shared types, constants and register indexes for the color-key layer compositor.
package ckl_pkg;

   localparam int NUM_LAYERS          = 4;
   localparam int MAX_DIM             = 4096;
   localparam int INPUT_LAYERS        = 4;
   localparam int CURSOR_DEFAULT_SIZE = 16;

   localparam int PIX_W   = 32;
   localparam int POS_W   = 12;
   localparam int DIM_W   = 13;
   localparam int MASK_W  = 4;
   localparam int INDEX_W = 3;

   localparam int REQ_DATA_W = PIX_W * INPUT_LAYERS;
   localparam int RSP_DATA_W = PIX_W + 2 * POS_W;

   typedef enum logic [INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_LAYER_ENABLE = 3'd2,
      REG_CURSOR_MODE  = 3'd3,
      REG_CURSOR_X     = 3'd4,
      REG_CURSOR_Y     = 3'd5,
      REG_CURSOR_W     = 3'd6,
      REG_CURSOR_H     = 3'd7
   } reg_index_type;

   typedef logic [INPUT_LAYERS-1:0][PIX_W-1:0] layer_pix_type;

   typedef struct packed {
      logic                    mode;
      logic signed [DIM_W-1:0] x;
      logic signed [DIM_W-1:0] y;
      logic        [DIM_W-1:0] w;
      logic        [DIM_W-1:0] h;
   } cursor_cfg_type;

endpackage

FILE: sv/ckl_blend.sv
// Per-pixel layer selection: color-key overlays followed by the clipped cursor.
module ckl_blend import ckl_pkg::*; (
   input  layer_pix_type       layer_pix,
   input  logic [POS_W-1:0]    col,
   input  logic [POS_W-1:0]    row,
   input  logic [MASK_W-1:0]   enable_mask,
   input  cursor_cfg_type      cursor,
   output logic [PIX_W-1:0]    pixel
);

   localparam int EXT_W = DIM_W + 2;

   logic                    cursor_on;
   logic [DIM_W-1:0]        cur_w;
   logic [DIM_W-1:0]        cur_h;
   logic signed [EXT_W-1:0] x_lo;
   logic signed [EXT_W-1:0] y_lo;
   logic signed [EXT_W-1:0] x_hi;
   logic signed [EXT_W-1:0] y_hi;
   logic signed [EXT_W-1:0] col_s;
   logic signed [EXT_W-1:0] row_s;
   logic                    in_cursor;
   logic [PIX_W-1:0]        layered;

   // Ordinary overlays: higher index wins where its pixel is nonzero.
   always_comb begin
      layered = layer_pix[0];
      for (int i = 1; i < INPUT_LAYERS; i++) begin
         if (i < NUM_LAYERS && enable_mask[i] && !(i == 1 && cursor.mode) &&
             layer_pix[i] != '0) begin
            layered = layer_pix[i];
         end
      end
   end

   assign cursor_on = cursor.mode && enable_mask[1];
   assign cur_w     = (cursor.w != '0) ? cursor.w : DIM_W'(CURSOR_DEFAULT_SIZE);
   assign cur_h     = (cursor.h != '0) ? cursor.h : DIM_W'(CURSOR_DEFAULT_SIZE);

   // Signed compares keep a cursor partly off screen correctly clipped.
   assign x_lo  = EXT_W'(cursor.x);
   assign y_lo  = EXT_W'(cursor.y);
   assign x_hi  = x_lo + $signed({2'b00, cur_w});
   assign y_hi  = y_lo + $signed({2'b00, cur_h});
   assign col_s = $signed({{(EXT_W-POS_W){1'b0}}, col});
   assign row_s = $signed({{(EXT_W-POS_W){1'b0}}, row});

   assign in_cursor = (col_s >= x_lo) && (col_s < x_hi) && (row_s >= y_lo) && (row_s < y_hi);

   assign pixel = (cursor_on && in_cursor && layer_pix[1] != '0) ? layer_pix[1] : layered;

endmodule

FILE: sv/color_key_layer_compositor.sv
// Color-key layer compositor top level: raster counters, two-stage pipeline, registers.
// Two register stages, input and result; an accepted transaction passes through the input
// stage and then the result register before it shows on rsp_tvalid.
// Throughput: one pixel per cycle; req_tready drops only when both stages hold
// data and rsp_tready is low.
// Reset clears the pipeline and the column/row counters and loads the register
// defaults (640 x 480, base layer only, cursor off, cursor at origin, size zero, shown as 16).
module color_key_layer_compositor import ckl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // base_pixel, layer_one_pixel, layer_two_pixel, layer_three_pixel (lowest bits first)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_pixel, pixel_col, pixel_row (lowest bits first)
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [INDEX_W-1:0]    csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int SIZE_W = DIM_W + 1;
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);

   // Configuration registers
   logic [DIM_W-1:0]  frame_width_ff;
   logic [DIM_W-1:0]  frame_height_ff;
   logic [MASK_W-1:0] layer_enable_ff;
   cursor_cfg_type    cursor_ff;

   // Raster counters
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_ff, row_in;

   // Input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [REQ_DATA_W-1:0] s1_data_ff;
   logic [POS_W-1:0]      s1_col_ff;
   logic [POS_W-1:0]      s1_row_ff;
   logic                  s1_last_ff;

   // Result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   logic              out_adv;
   logic              s1_adv;
   logic              req_acc;
   logic [SIZE_W-1:0] width_eff;
   logic [SIZE_W-1:0] height_eff;
   logic              end_line;
   logic              end_frame;
   logic [PIX_W-1:0]  blend_pix;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(640);
         frame_height_ff <= DIM_W'(480);
         layer_enable_ff <= MASK_W'(1);
         cursor_ff       <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            REG_LAYER_ENABLE: layer_enable_ff <= csr_wdata[MASK_W-1:0];
            REG_CURSOR_MODE:  cursor_ff.mode  <= csr_wdata[0];
            REG_CURSOR_X:     cursor_ff.x     <= csr_wdata;
            REG_CURSOR_Y:     cursor_ff.y     <= csr_wdata;
            REG_CURSOR_W:     cursor_ff.w     <= csr_wdata;
            REG_CURSOR_H:     cursor_ff.h     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero size counts as one; sizes above the maximum are clamped.
   always_comb begin
      width_eff = {1'b0, frame_width_ff};
      if (frame_width_ff == '0) width_eff = SIZE_W'(1);
      else if (width_eff > MAX_SIZE) width_eff = MAX_SIZE;
      height_eff = {1'b0, frame_height_ff};
      if (frame_height_ff == '0) height_eff = SIZE_W'(1);
      else if (height_eff > MAX_SIZE) height_eff = MAX_SIZE;
   end

   assign end_line  = SIZE_W'(col_ff) >= (width_eff - SIZE_W'(1));
   assign end_frame = end_line && (SIZE_W'(row_ff) >= (height_eff - SIZE_W'(1)));

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = !s1_valid_ff || out_adv;
   assign req_tready = s1_adv;
   assign req_acc    = req_tvalid && s1_adv;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_acc) begin
         priority if (end_frame) begin
            col_in = '0;
            row_in = '0;
         end else if (end_line) begin
            col_in = '0;
            row_in = row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   assign s1_valid_in  = s1_adv ? req_tvalid : s1_valid_ff;
   assign rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= req_tdata;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_last_ff <= end_frame;
      end
      if (out_adv && s1_valid_ff) begin
         rsp_data_ff <= {s1_row_ff, s1_col_ff, blend_pix};
         rsp_last_ff <= s1_last_ff;
      end
   end

   ckl_blend u_blend (
      .layer_pix   (layer_pix_type'(s1_data_ff)),
      .col         (s1_col_ff),
      .row         (s1_row_ff),
      .enable_mask (layer_enable_ff),
      .cursor      (cursor_ff),
      .pixel       (blend_pix)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sv/ckl_checker.sv
// Port-level checker for the compositor, bound to the top level.
module ckl_checker import ckl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic             rsp_acc;
   logic [POS_W-1:0] out_col;
   logic [POS_W-1:0] out_row;
   logic             have_prev_ff;
   logic             frame_start_ff;
   logic [POS_W-1:0] prev_col_ff;
   logic [POS_W-1:0] prev_row_ff;

   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign out_col = rsp_tdata[PIX_W +: POS_W];
   assign out_row = rsp_tdata[PIX_W + POS_W +: POS_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff   <= 1'b0;
         frame_start_ff <= 1'b1;
      end else if (rsp_acc) begin
         have_prev_ff   <= 1'b1;
         frame_start_ff <= rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_acc) begin
         prev_col_ff <= out_col;
         prev_row_ff <= out_row;
      end
   end

   // The result register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Every frame starts at the origin.
   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && frame_start_ff |-> out_col == '0 && out_row == '0)
      else $error("frame did not start at column zero, row zero");

   // Within a line the column steps by one and the row stays.
   a_col_step: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && have_prev_ff && out_col != '0 |->
         out_col == prev_col_ff + POS_W'(1) && out_row == prev_row_ff)
      else $error("column did not advance by one within a line");

endmodule

bind color_key_layer_compositor ckl_checker u_ckl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
